// File: rtl/core/pcbp_pkg.sv
// Shared constants, types and sequencer states for the bounded partition counter.
package pcbp_pkg;

    // Largest target the ways table covers
    localparam int MAX_TARGET = 511;
    localparam int DEPTH      = MAX_TARGET + 1;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int FIELD_W    = 9;
    localparam int WAYS_W     = 64;
    // Table entry: overflow mark above the 64-bit count
    localparam int ENTRY_W    = WAYS_W + 1;

    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [ENTRY_W-1:0] entry_t;

    // One table operation handed from the sequencer to the update stage
    typedef struct packed {
        logic  valid;
        logic  clear;
        logic  last;
        addr_t addr;
    } op_t;

    // Final count of the request
    typedef struct packed {
        logic [WAYS_W-1:0] ways;
        logic              sat;
    } res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

endpackage

// File: rtl/core/pcbp_req_if.sv
// Request channel: target sum and largest allowed part.
interface pcbp_req_if import pcbp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] target;
    logic [FIELD_W-1:0] max_part;

    modport source (output valid, output target, output max_part, input ready);
    modport sink (input valid, input target, input max_part, output ready);
endinterface

// File: rtl/core/pcbp_rsp_if.sv
// Response channel: partition count and saturation flag.
interface pcbp_rsp_if import pcbp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WAYS_W-1:0] ways;
    logic              saturated;

    modport source (output valid, output ways, output saturated, input ready);
    modport sink (input valid, input ways, input saturated, output ready);
endinterface

// File: rtl/core/pcbp_ram.sv
// Generic synchronous RAM: one write port, two registered read ports.
module pcbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, and read old data on a same-address collision
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// File: rtl/core/pcbp_upd.sv
// Update stage: saturating add of two table entries with forwarding of the last write.
module pcbp_upd import pcbp_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    input  op_t    op,
    input  addr_t  rd_b,
    input  entry_t rdata_a,
    input  entry_t rdata_b,
    output logic   we,
    output addr_t  waddr,
    output entry_t wdata,
    output res_t   res
);

    op_t    opq_reg;
    addr_t  baddr_reg;
    logic   fwd_valid_reg;
    addr_t  fwd_addr_reg;
    entry_t fwd_data_reg;
    res_t   res_reg;

    entry_t          val_a;
    entry_t          val_b;
    logic [WAYS_W:0] sum;
    logic            mark;

    always_comb
    begin
        // Take the entry written last cycle, the RAM still shows the old one
        val_a = (fwd_valid_reg && fwd_addr_reg == opq_reg.addr) ? fwd_data_reg : rdata_a;
        val_b = (fwd_valid_reg && fwd_addr_reg == baddr_reg) ? fwd_data_reg : rdata_b;
        sum   = {1'b0, val_a[WAYS_W-1:0]} + {1'b0, val_b[WAYS_W-1:0]};
        mark  = val_a[WAYS_W] | val_b[WAYS_W] | sum[WAYS_W];

        // Seed the table on clear, otherwise saturate or store the sum
        we    = opq_reg.valid;
        waddr = opq_reg.addr;
        if (opq_reg.clear)
        begin
            wdata = {1'b0, (opq_reg.addr == '0) ? WAYS_W'(1) : WAYS_W'(0)};
        end
        else if (mark)
        begin
            wdata = {1'b1, {WAYS_W{1'b1}}};
        end
        else
        begin
            wdata = {1'b0, sum[WAYS_W-1:0]};
        end
        res = res_reg;
    end

    // Hold the operation for its read cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opq_reg       <= '0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            opq_reg       <= op;
            fwd_valid_reg <= we;
        end
    end

    // Track the last write and capture the final count
    always_ff @(posedge clk)
    begin
        baddr_reg    <= rd_b;
        fwd_addr_reg <= waddr;
        fwd_data_reg <= wdata;
        if (we && opq_reg.last)
        begin
            res_reg.ways <= wdata[WAYS_W-1:0];
            res_reg.sat  <= wdata[WAYS_W];
        end
    end

endmodule

// File: rtl/core/pcbp_ctrl.sv
// Sequencer: walks the clear and update passes and holds the response register.
module pcbp_ctrl import pcbp_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    pcbp_req_if.sink          req,
    pcbp_rsp_if.source        rsp,
    output op_t               op,
    output addr_t             rd_a,
    output addr_t             rd_b,
    input  res_t              res
);

    state_t            state_reg, state_next;
    addr_t             s_reg, s_next;
    addr_t             part_reg, part_next;
    addr_t             tgt_reg, tgt_next;
    addr_t             bound_reg, bound_next;
    logic              zero_reg, zero_next;
    logic              out_valid_reg, out_valid_next;
    logic [WAYS_W-1:0] out_ways_reg, out_ways_next;
    logic              out_sat_reg, out_sat_next;

    always_comb
    begin
        state_next     = state_reg;
        s_next         = s_reg;
        part_next      = part_reg;
        tgt_next       = tgt_reg;
        bound_next     = bound_reg;
        zero_next      = zero_reg;
        out_valid_next = out_valid_reg;
        out_ways_next  = out_ways_reg;
        out_sat_next   = out_sat_reg;
        op             = '0;
        rd_a           = s_reg;
        rd_b           = s_reg - part_reg;
        req.ready      = (state_reg == ST_IDLE);

        // Drop the response once taken
        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    if (int'(req.target) <= MAX_TARGET)
                    begin
                        tgt_next   = ADDR_W'(req.target);
                        bound_next = (req.max_part > req.target) ? ADDR_W'(req.target)
                                                                 : ADDR_W'(req.max_part);
                        s_next     = '0;
                        zero_next  = 1'b0;
                        state_next = ST_CLEAR;
                    end
                    else
                    begin
                        zero_next  = 1'b1;
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_CLEAR:
            begin
                // Seed entries 0..target
                op.valid = 1'b1;
                op.clear = 1'b1;
                op.addr  = s_reg;
                if (s_reg == tgt_reg)
                begin
                    if (bound_reg == '0)
                    begin
                        op.last    = 1'b1;
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        part_next  = ADDR_W'(1);
                        s_next     = ADDR_W'(1);
                        state_next = ST_SCAN;
                    end
                end
                else
                begin
                    s_next = s_reg + ADDR_W'(1);
                end
            end
            ST_SCAN:
            begin
                // Add ways[s - part] into ways[s], one sum per cycle
                op.valid = 1'b1;
                op.addr  = s_reg;
                op.last  = (s_reg == tgt_reg) && (part_reg == bound_reg);
                if (s_reg == tgt_reg)
                begin
                    if (part_reg == bound_reg)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        part_next = part_reg + ADDR_W'(1);
                        s_next    = part_reg + ADDR_W'(1);
                    end
                end
                else
                begin
                    s_next = s_reg + ADDR_W'(1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // Load the response register once it is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_ways_next  = zero_reg ? '0 : res.ways;
                    out_sat_next   = zero_reg ? 1'b0 : res.sat;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        rsp.valid     = out_valid_reg;
        rsp.ways      = out_ways_reg;
        rsp.saturated = out_sat_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg        <= s_next;
        part_reg     <= part_next;
        tgt_reg      <= tgt_next;
        bound_reg    <= bound_next;
        zero_reg     <= zero_next;
        out_ways_reg <= out_ways_next;
        out_sat_reg  <= out_sat_next;
    end

endmodule

// File: rtl/core/partition_count_bounded_parts.sv
// Throughput: one request at a time; the ways table takes one read-add-write per cycle
// through its single write port, with the last write forwarded to the next read.
// Reset: asynchronous, active low; clears the sequencer, the update valids and response valid.
// The ways table needs no clearing, every request seeds the entries it reads.
module partition_count_bounded_parts import pcbp_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    pcbp_req_if.sink   req,
    pcbp_rsp_if.source rsp
);

    op_t    op;
    addr_t  rd_a;
    addr_t  rd_b;
    entry_t rdata_a;
    entry_t rdata_b;
    logic   we;
    addr_t  waddr;
    entry_t wdata;
    res_t   res;

    pcbp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .op    (op),
        .rd_a  (rd_a),
        .rd_b  (rd_b),
        .res   (res)
    );

    pcbp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ways_ram (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (rd_a),
        .raddr_b (rd_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    pcbp_upd u_upd (
        .clk     (clk),
        .rst_n   (rst_n),
        .op      (op),
        .rd_b    (rd_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .res     (res)
    );

endmodule

// File: rtl/core/pcbp_chk.sv
// Port-level checks on the partition counter, bound to the top level.
module pcbp_chk import pcbp_pkg::*; (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic [WAYS_W-1:0] rsp_ways,
    input logic              rsp_saturated
);

    // A stalled response holds its count
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ways) && $stable(rsp_saturated))
    else $error("response changed while stalled");

    // One request at a time: ready drops after a request is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
    else $error("second request taken while busy");

    // A saturated count reads as all ones
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_saturated |-> rsp_ways == {WAYS_W{1'b1}})
    else $error("saturated response without all-ones count");

    // No response during reset
    assert property (@(posedge clk)
        !rst_n |-> !rsp_valid)
    else $error("response valid during reset");

endmodule

bind partition_count_bounded_parts pcbp_chk u_pcbp_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_ways      (rsp.ways),
    .rsp_saturated (rsp.saturated)
);

// File: test/partition_count_bounded_parts_chk.sv
`timescale 1ns / 1ps
// Checker for the bounded partition counter: predicts each count and compares responses.
module partition_count_bounded_parts_chk import pcbp_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    pcbp_req_if  req,
    pcbp_rsp_if  rsp,
    output int   fail_cnt,
    output int   owed
);

    // Counts still due, oldest request first
    res_t counts_due[$];

    // Count partitions of tgt into parts no larger than lim, saturating at all ones
    function automatic res_t count_partitions(input logic [FIELD_W-1:0] tgt,
                                              input logic [FIELD_W-1:0] lim);
        logic [WAYS_W-1:0] tbl [0:MAX_TARGET];
        logic              marks [0:MAX_TARGET];
        logic [WAYS_W:0]   sum;
        logic              mark;
        int                t;
        int                bound;
        res_t              r;

        t     = int'(tgt);
        bound = int'((lim > tgt) ? tgt : lim);
        r.ways = '0;
        r.sat  = 1'b0;
        if (t > MAX_TARGET)
        begin
            return r;
        end
        // Seed: one way to make zero, none yet for anything else
        for (int s = 0; s <= t; s++)
        begin
            tbl[s]   = (s == 0) ? WAYS_W'(1) : WAYS_W'(0);
            marks[s] = 1'b0;
        end
        // Fold in one part size at a time
        for (int p = 1; p <= bound; p++)
        begin
            for (int s = p; s <= t; s++)
            begin
                sum  = {1'b0, tbl[s]} + {1'b0, tbl[s-p]};
                mark = marks[s] | marks[s-p] | sum[WAYS_W];
                if (mark)
                begin
                    tbl[s]   = '1;
                    marks[s] = 1'b1;
                end
                else
                begin
                    tbl[s] = sum[WAYS_W-1:0];
                end
            end
        end
        r.ways = tbl[t];
        r.sat  = marks[t];
        return r;
    endfunction

    // Match each response against the oldest count due, then log new requests
    always @(posedge clk)
    begin : watch
        res_t want;
        int   n_bad;

        n_bad = 0;
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (counts_due.size() == 0)
                begin
                    $error("response with no request outstanding: ways %0d saturated %0d",
                           rsp.ways, rsp.saturated);
                    n_bad++;
                end
                else
                begin
                    want = counts_due.pop_front();
                    if (rsp.ways !== want.ways)
                    begin
                        $error("ways: expected %0d, got %0d", want.ways, rsp.ways);
                        n_bad++;
                    end
                    if (rsp.saturated !== want.sat)
                    begin
                        $error("saturated: expected %0d, got %0d", want.sat, rsp.saturated);
                        n_bad++;
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                counts_due.push_back(count_partitions(req.target, req.max_part));
            end
            fail_cnt <= fail_cnt + n_bad;
            owed     <= counts_due.size();
        end
    end

endmodule

// File: test/partition_count_bounded_parts_tb.sv
`timescale 1ns / 1ps
// Testbench top for the bounded partition counter: clock, reset, stimulus and verdict.
module partition_count_bounded_parts_tb;
    import pcbp_pkg::*;

    logic   clk = 1'b0;
    logic   rst_n;
    int     fail_cnt;
    int     owed;
    int     send_idle_pct;
    int     rcv_stall_pct;
    int     hold_ask;
    longint budget;
    longint cycles = 0;

    pcbp_req_if req();
    pcbp_rsp_if rsp();

    partition_count_bounded_parts u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    partition_count_bounded_parts_chk u_chk (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .rsp      (rsp),
        .fail_cnt (fail_cnt),
        .owed     (owed)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Drop the run once it overshoots a limit scaled by the work handed in so far
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 200000 + 4 * budget)
        begin
            $display("partition_count_bounded_parts_tb: done, errors");
            $finish;
        end
    end

    // Response side: random stalls, plus a long hold-off whenever one is asked for
    initial
    begin : rsp_drive
        int seen;
        int hold_left;

        seen      = 0;
        hold_left = 0;
        rsp.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_ask != seen)
            begin
                seen      = hold_ask;
                hold_left = 4000;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp.ready <= 1'b0;
            end
            else
            begin
                rsp.ready <= ($urandom_range(99) >= rcv_stall_pct);
            end
        end
    end

    // Offer one request, idling first at the current rate, and hold it until taken
    task automatic send_request(input logic [FIELD_W-1:0] t, input logic [FIELD_W-1:0] b);
        int b_eff;

        b_eff = int'((b > t) ? t : b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid    <= 1'b1;
        req.target   <= t;
        req.max_part <= b;
        do
            @(posedge clk);
        while (!req.ready);
        budget = budget + 20 + (int'(t) + 1) + b_eff * (int'(t) + 1);
    endtask

    // Wait until every request has been answered
    task automatic drain_counts();
        req.valid <= 1'b0;
        do
            @(posedge clk);
        while (owed != 0);
    endtask

    initial
    begin : stimulus
        int               kind;
        logic [FIELD_W-1:0] t;
        logic [FIELD_W-1:0] b;

        rst_n         = 1'b0;
        req.valid     = 1'b0;
        req.target    = '0;
        req.max_part  = '0;
        send_idle_pct = 0;
        rcv_stall_pct = 0;
        hold_ask      = 0;
        budget        = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero target, zero bound, bound above target, extremes, saturation
        send_request(9'd0,   9'd0);
        send_request(9'd0,   9'd511);
        send_request(9'd7,   9'd0);
        send_request(9'd511, 9'd0);
        send_request(9'd1,   9'd1);
        send_request(9'd1,   9'd511);
        send_request(9'd6,   9'd20);
        send_request(9'd10,  9'd3);
        send_request(9'd20,  9'd20);
        send_request(9'd511, 9'd1);
        send_request(9'd511, 9'd2);
        send_request(9'd256, 9'd3);
        send_request(9'd400, 9'd400);
        send_request(9'd416, 9'd416);
        send_request(9'd511, 9'd511);
        drain_counts();

        // Hold off the response side while requests keep coming, then pause
        hold_ask <= hold_ask + 1;
        repeat (5)
        begin
            send_request(9'($urandom_range(20, 3)), 9'($urandom_range(12)));
        end
        drain_counts();

        // Random phases: no idling, sender idle, receiver stalling, both
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1) ? 56 : (ph == 3) ? 32 : 0;
            rcv_stall_pct = (ph == 2) ? 56 : (ph == 3) ? 32 : 0;
            for (int i = 0; i < 25; i++)
            begin
                kind = int'($urandom_range(99));
                if (kind < 55)
                begin
                    t = 9'($urandom_range(40));
                    b = 9'($urandom_range(48));
                end
                else if (kind < 72)
                begin
                    t = 9'($urandom_range(511));
                    b = 9'($urandom_range(6));
                end
                else if (kind < 88)
                begin
                    t = 9'($urandom_range(40));
                    b = 9'($urandom_range(511, 256));
                end
                else
                begin
                    t = 9'($urandom_range(120, 40));
                    b = 9'($urandom_range(int'(t) + 5));
                end
                send_request(t, b);
            end
            drain_counts();
        end

        // Let any stray response show up before the verdict
        repeat (200) @(posedge clk);
        if (fail_cnt == 0)
        begin
            $display("partition_count_bounded_parts_tb: done, clean");
        end
        else
        begin
            $display("partition_count_bounded_parts_tb: done, errors");
        end
        $finish;
    end

endmodule

// File: partition_count_bounded_parts.f
rtl/core/pcbp_pkg.sv
rtl/core/pcbp_req_if.sv
rtl/core/pcbp_rsp_if.sv
rtl/core/pcbp_ram.sv
rtl/core/pcbp_upd.sv
rtl/core/pcbp_ctrl.sv
rtl/core/partition_count_bounded_parts.sv
rtl/core/pcbp_chk.sv
test/partition_count_bounded_parts_chk.sv
test/partition_count_bounded_parts_tb.sv
